[rtl/srtf_scheduler_macros.svh]
// assertion helpers included by srtf_scheduler.sv
`ifndef SRTF_SCHEDULER_MACROS_SVH
`define SRTF_SCHEDULER_MACROS_SVH

// condition that holds in the same cycle
`define SRTF_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that holds in the next cycle
`define SRTF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/srtf_pkg.sv]
package srtf_pkg;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [7:0]  job_id;
		logic [15:0] remaining;
		logic [15:0] burst;
		logic [31:0] arrival;
		logic [31:0] first_start;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic sample;
		logic live;
	} pick_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_FINISH,
		S_RESULT
	} state_t;

endpackage

[rtl/srtf_scheduler.sv]
// channel   | direction | handshake            | words
// ----------+-----------+----------------------+-----------------------------------------
// command   | in        | start high, busy low | op, job_id, burst_len
// result    | out       | result_stb, 1 cycle  | busy_res, running_id, done_res,
//           |           |                      | turnaround, waiting, response, status
//
// an arrival writes the table at the accept edge, and the result
// word is strobed in the next cycle
// a tick runs through the accept cycle, one table read a cycle through
// the single read port of the slot memory, a drain cycle, then write-back, finish
// math and strobe
// reset clears the valid and started bits and the time; the slot memory is not cleared
// busy is high from the accept edge until after the strobe; the receiver cannot stall
module srtf_scheduler #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [7:0]  job_id,
	input  logic [15:0] burst_len,
	output logic        result_stb,
	output logic        busy_res,
	output logic [7:0]  running_id,
	output logic        done_res,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	output logic [31:0] response,
	output logic [1:0]  status
);
	import srtf_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// fsm
	state_t state_q, state_nxt;
	logic   accept;
	logic   rd_issue;
	logic   scan_done;
	logic   in_update;

	// per-slot flags, cleared by reset
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] started_q;

	// slot memory: one write port, one registered read port
	entry_t           mem [TABLE_DEPTH];
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	entry_t           rd_entry_s1;

	// scan pointer and read pipeline
	logic [CNT_W-1:0] rd_cnt_q;
	logic             sample_s1;
	logic [IDX_W-1:0] idx_s1;

	// minimum finder
	pick_ctl_t        pick_ctl;
	logic             found;
	logic [IDX_W-1:0] best_idx;
	entry_t           best;

	// lowest free slot
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	// write-back values
	logic [15:0] rem_dec;
	logic [31:0] fs_new;
	logic [31:0] now_inc;

	// time and finish math
	logic [31:0] now_time_q;
	logic [31:0] arrival_q;
	logic [32:0] arr_burst_q;
	logic [31:0] fs_q;

	// result word
	logic        busy_res_q;
	logic [7:0]  running_id_q;
	logic        done_res_q;
	logic [31:0] turnaround_q;
	logic [31:0] waiting_q;
	logic [31:0] response_q;
	logic [1:0]  status_q;

	assign accept = start && !busy;

	// ---------------- control ----------------

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_nxt = (op == OP_TICK) ? S_SCAN : S_RESULT;
			S_SCAN:   if (scan_done) state_nxt = S_UPDATE;
			S_UPDATE: state_nxt = S_FINISH;
			S_FINISH: state_nxt = S_RESULT;
			S_RESULT: state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != S_IDLE);
		result_stb = (state_q == S_RESULT);
		rd_issue   = (state_q == S_SCAN) && (rd_cnt_q != CNT_W'(TABLE_DEPTH));
		in_update  = (state_q == S_UPDATE);
		// last read data is consumed on the edge that ends this cycle
		scan_done  = (state_q == S_SCAN) && (rd_cnt_q == CNT_W'(TABLE_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ---------------- scan ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			sample_s1 <= 1'b0;
		end else begin
			sample_s1 <= rd_issue;
			if (state_q == S_IDLE) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
	end

	always_comb begin
		pick_ctl.clear  = (state_q == S_IDLE);
		pick_ctl.sample = sample_s1;
		pick_ctl.live   = valid_q[idx_s1];
	end

	srtf_pick #(
		.IDX_W (IDX_W)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pick_ctl),
		.entry    (rd_entry_s1),
		.idx      (idx_s1),
		.found    (found),
		.best_idx (best_idx),
		.best     (best)
	);

	// ---------------- slot memory ----------------

	// lowest slot with a clear valid bit
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		rem_dec = (best.remaining != '0) ? best.remaining - 16'd1 : best.remaining;
		fs_new  = started_q[best_idx] ? best.first_start : now_time_q;
		now_inc = (now_time_q == '1) ? now_time_q : now_time_q + 32'd1;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = free_idx;
		mem_wd = '{job_id: job_id, remaining: burst_len, burst: burst_len,
			arrival: now_time_q, first_start: '0};
		if (in_update) begin
			mem_we = found;
			mem_wa = best_idx;
			mem_wd = '{job_id: best.job_id, remaining: rem_dec, burst: best.burst,
				arrival: best.arrival, first_start: fs_new};
		end else if (accept && (op == OP_ARRIVE) && (burst_len != '0) && free_found) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_entry_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
		end
	end

	// ---------------- slot flags and time ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			started_q  <= '0;
			now_time_q <= '0;
		end else begin
			if (accept && (op == OP_ARRIVE) && (burst_len != '0) && free_found) begin
				valid_q[free_idx]   <= 1'b1;
				started_q[free_idx] <= 1'b0;
			end
			if (in_update) begin
				now_time_q <= now_inc;
				if (found) begin
					// finishing job frees its slot
					valid_q[best_idx]   <= (rem_dec != '0);
					started_q[best_idx] <= (rem_dec != '0);
				end
			end
		end
	end

	// ---------------- result word ----------------

	always_ff @(posedge clk) begin
		if (accept && (op == OP_ARRIVE)) begin
			busy_res_q   <= 1'b0;
			running_id_q <= '0;
			done_res_q   <= 1'b0;
			turnaround_q <= '0;
			waiting_q    <= '0;
			response_q   <= '0;
			if (burst_len == '0) begin
				status_q <= ST_ZERO;
			end else if (!free_found) begin
				status_q <= ST_FULL;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (in_update) begin
			busy_res_q   <= found;
			running_id_q <= found ? best.job_id : '0;
			done_res_q   <= found && (rem_dec == '0);
			status_q     <= ST_OK;
			arrival_q    <= best.arrival;
			arr_burst_q  <= {1'b0, best.arrival} + {17'd0, best.burst};
			fs_q         <= fs_new;
		end
		if (state_q == S_FINISH) begin
			// now_time_q already holds the finish time here
			if (done_res_q) begin
				turnaround_q <= now_time_q - arrival_q;
				response_q   <= fs_q - arrival_q;
				// waiting saturates at zero when time has pinned at its maximum
				waiting_q    <= ({1'b0, now_time_q} >= arr_burst_q) ?
					now_time_q - arr_burst_q[31:0] : '0;
			end else begin
				turnaround_q <= '0;
				response_q   <= '0;
				waiting_q    <= '0;
			end
		end
	end

	assign busy_res   = busy_res_q;
	assign running_id = running_id_q;
	assign done_res   = done_res_q;
	assign turnaround = turnaround_q;
	assign waiting    = waiting_q;
	assign response   = response_q;
	assign status     = status_q;

	// ---------------- checks ----------------

	`include "srtf_scheduler_macros.svh"

	`SRTF_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
	`SRTF_ASSERT_NEXT(a_strobe_once, result_stb, !busy && !result_stb, "result strobe not single")
	`SRTF_ASSERT_NOW(a_done_ran, result_stb && done_res, busy_res, "job finished without running")
	`SRTF_ASSERT_NOW(a_reject_idle, result_stb && (status != ST_OK), !busy_res && !done_res,
		"rejected arrival reported a run")

endmodule

[rtl/srtf_pick.sv]
module srtf_pick #(
	parameter int IDX_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srtf_pkg::pick_ctl_t ctl,
	input  srtf_pkg::entry_t   entry,
	input  logic [IDX_W-1:0]   idx,
	output logic               found,
	output logic [IDX_W-1:0]   best_idx,
	output srtf_pkg::entry_t   best
);
	import srtf_pkg::*;

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;
	logic             better;

	// strictly better only: equal keys keep the lower slot seen first
	always_comb begin
		better = (entry.remaining < best_q.remaining) ||
			((entry.remaining == best_q.remaining) && (entry.arrival < best_q.arrival));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (ctl.sample && ctl.live) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sample && ctl.live && (!found_q || better)) begin
			best_q     <= entry;
			best_idx_q <= idx;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best     = best_q;

endmodule
